### rtl/core/isut_pkg.sv
// ----------------------------------------------------------------------------
// isut_pkg
// Shared constants and codes for the interval set union table.
// ----------------------------------------------------------------------------
package isut_pkg;

  localparam int unsigned BoundW       = 32;
  localparam int unsigned IdxW         = 6;
  localparam int unsigned CountW       = 7;
  localparam int unsigned OpW          = 2;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned MaxIntervals = 64;

  localparam logic [OpW-1:0] OpInsert = 2'd0;
  localparam logic [OpW-1:0] OpRead   = 2'd1;
  localparam logic [OpW-1:0] OpClear  = 2'd2;
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  localparam logic [StatusW-1:0] StOk        = 2'd0;
  localparam logic [StatusW-1:0] StFull      = 2'd1;
  localparam logic [StatusW-1:0] StReadRange = 2'd2;

endpackage

### rtl/core/isut_if.sv
// ----------------------------------------------------------------------------
// isut_in_if / isut_out_if
// Valid/ready channels for requests and results of the interval table.
// ----------------------------------------------------------------------------
interface isut_in_if;
  import isut_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OpW-1:0]           opcode;
  logic signed [BoundW-1:0] range_low;
  logic signed [BoundW-1:0] range_high;
  logic [IdxW-1:0]          entry_index;

  modport source (output valid, opcode, range_low, range_high, entry_index, input ready);
  modport sink   (input valid, opcode, range_low, range_high, entry_index, output ready);
endinterface

interface isut_out_if;
  import isut_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [StatusW-1:0]       status;
  logic [CountW-1:0]        interval_count;
  logic signed [BoundW-1:0] span_low;
  logic signed [BoundW-1:0] span_high;
  logic signed [BoundW-1:0] read_low;
  logic signed [BoundW-1:0] read_high;

  modport source (output valid, status, interval_count, span_low, span_high, read_low,
                  read_high, input ready);
  modport sink   (input valid, status, interval_count, span_low, span_high, read_low,
                  read_high, output ready);
endinterface

### rtl/core/isut_ram.sv
// ----------------------------------------------------------------------------
// isut_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module isut_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/interval_set_union_table_core.sv
// ----------------------------------------------------------------------------
// interval_set_union_table_core
// Sorted table of disjoint closed intervals with merging insert, read, clear.
// ----------------------------------------------------------------------------
// Entries live in one RAM holding both bounds of an interval. An insert scans
// all n stored entries, then either shifts the tail up by one entry and writes
// the new entry or writes the merged entry and shifts the tail down, one entry
// per cycle, limited by the single read and single write port of the RAM. The
// next transaction is accepted while a result still waits in the output
// register. Entries are never cleared; the count alone tells which are valid.
module interval_set_union_table_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  isut_in_if.sink    req_i,
  isut_out_if.source rsp_o
);
  import isut_pkg::*;

  localparam int unsigned MAX_INTERVALS = MaxIntervals;
  localparam int unsigned AW = $clog2(MAX_INTERVALS);
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned DW = 2 * BoundW;

  typedef enum logic [2:0] {
    IDLE, READ_WAIT, SCAN, DECIDE, SHIFT_UP, WRITE_NEW, SHIFT_DN, FINISH
  } state_e;

  state_e                   state_q;
  logic                     idx_ok_q;
  logic [CW-1:0]            n_q, ptr_q, f_q, l_q, rem_q;
  logic                     pend_q;
  logic [AW-1:0]            wa_q;
  logic signed [BoundW-1:0] lo_q, hi_q, mlo_q, mhi_q;
  logic signed [BoundW-1:0] span_lo_q, span_hi_q, rlo_q, rhi_q;
  logic [StatusW-1:0]       status_q;
  logic                     out_valid_q;
  logic [StatusW-1:0]       out_status_q;
  logic [CountW-1:0]        out_count_q;
  logic signed [BoundW-1:0] out_span_lo_q, out_span_hi_q, out_rlo_q, out_rhi_q;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [DW-1:0]            mem_wdata, mem_rdata;
  logic signed [BoundW-1:0] ent_lo, ent_hi, in_lo, in_hi;
  logic [CW-1:0]            ptr_m1, ptr_mrem;

  assign ent_lo   = $signed(mem_rdata[DW-1:BoundW]);
  assign ent_hi   = $signed(mem_rdata[BoundW-1:0]);
  assign in_lo    = (req_i.range_low > req_i.range_high) ? req_i.range_high : req_i.range_low;
  assign in_hi    = (req_i.range_low > req_i.range_high) ? req_i.range_low : req_i.range_high;
  assign ptr_m1   = ptr_q - CW'(1);
  assign ptr_mrem = ptr_q - rem_q;

  assign req_i.ready          = (state_q == IDLE);
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.interval_count = out_count_q;
  assign rsp_o.span_low       = out_span_lo_q;
  assign rsp_o.span_high      = out_span_hi_q;
  assign rsp_o.read_low       = out_rlo_q;
  assign rsp_o.read_high      = out_rhi_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wa_q;
    mem_wdata = mem_rdata;
    mem_raddr = ptr_q[AW-1:0];
    case (state_q)
      IDLE: begin
        mem_raddr = AW'(req_i.entry_index);
      end
      SHIFT_UP: begin
        mem_raddr = ptr_m1[AW-1:0];
        mem_we    = pend_q;
      end
      SHIFT_DN: begin
        mem_we = pend_q;
      end
      WRITE_NEW: begin
        mem_we    = 1'b1;
        mem_waddr = f_q[AW-1:0];
        mem_wdata = {mlo_q, mhi_q};
      end
      default: begin
      end
    endcase
  end

  isut_ram #(.Width(DW), .Depth(MAX_INTERVALS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      span_lo_q   <= '0;
      span_hi_q   <= '0;
      pend_q      <= 1'b0;
    end else begin
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (req_i.valid) begin
            lo_q     <= in_lo;
            hi_q     <= in_hi;
            mlo_q    <= in_lo;
            mhi_q    <= in_hi;
            idx_ok_q <= (CountW'(req_i.entry_index) < CountW'(n_q));
            ptr_q    <= '0;
            f_q      <= '0;
            l_q      <= '0;
            pend_q   <= 1'b0;
            status_q <= StOk;
            rlo_q    <= '0;
            rhi_q    <= '0;
            case (req_i.opcode)
              OpInsert: state_q <= SCAN;
              OpRead:   state_q <= READ_WAIT;
              OpClear: begin
                n_q       <= '0;
                span_lo_q <= '0;
                span_hi_q <= '0;
                state_q   <= FINISH;
              end
              default:  state_q <= FINISH;
            endcase
          end
        end
        READ_WAIT: begin
          if (idx_ok_q) begin
            rlo_q <= ent_lo;
            rhi_q <= ent_hi;
          end else begin
            status_q <= StReadRange;
          end
          state_q <= FINISH;
        end
        SCAN: begin
          pend_q <= (ptr_q < n_q);
          if (ptr_q < n_q) begin
            ptr_q <= ptr_q + CW'(1);
          end
          if (pend_q) begin
            if (ent_hi < lo_q) begin
              f_q <= f_q + CW'(1);
            end
            if (ent_lo <= hi_q) begin
              l_q <= l_q + CW'(1);
            end
            if (ent_hi >= lo_q && ent_lo <= hi_q) begin
              if (ent_lo < mlo_q) begin
                mlo_q <= ent_lo;
              end
              if (ent_hi > mhi_q) begin
                mhi_q <= ent_hi;
              end
            end
          end
          if (ptr_q == n_q && !pend_q) begin
            state_q <= DECIDE;
          end
        end
        DECIDE: begin
          rem_q <= l_q - f_q - CW'(1);
          if (l_q == f_q) begin
            if (n_q == CW'(MAX_INTERVALS)) begin
              status_q <= StFull;
              state_q  <= FINISH;
            end else begin
              ptr_q   <= n_q;
              pend_q  <= 1'b0;
              state_q <= SHIFT_UP;
            end
          end else begin
            state_q <= WRITE_NEW;
          end
        end
        SHIFT_UP: begin
          pend_q <= (ptr_q > f_q);
          if (ptr_q > f_q) begin
            wa_q  <= ptr_q[AW-1:0];
            ptr_q <= ptr_m1;
          end
          if (ptr_q == f_q && !pend_q) begin
            state_q <= WRITE_NEW;
          end
        end
        WRITE_NEW: begin
          if (f_q == '0) begin
            span_lo_q <= mlo_q;
          end
          if (l_q == n_q) begin
            span_hi_q <= mhi_q;
          end
          if (l_q == f_q) begin
            n_q     <= n_q + CW'(1);
            state_q <= FINISH;
          end else if (rem_q != '0 && l_q < n_q) begin
            ptr_q   <= l_q;
            pend_q  <= 1'b0;
            state_q <= SHIFT_DN;
          end else begin
            n_q     <= n_q - rem_q;
            state_q <= FINISH;
          end
        end
        SHIFT_DN: begin
          pend_q <= (ptr_q < n_q);
          if (ptr_q < n_q) begin
            wa_q  <= ptr_mrem[AW-1:0];
            ptr_q <= ptr_q + CW'(1);
          end
          if (ptr_q == n_q && !pend_q) begin
            n_q     <= n_q - rem_q;
            state_q <= FINISH;
          end
        end
        FINISH: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q   <= 1'b1;
            out_status_q  <= status_q;
            out_count_q   <= CountW'(n_q);
            out_span_lo_q <= span_lo_q;
            out_span_hi_q <= span_hi_q;
            out_rlo_q     <= rlo_q;
            out_rhi_q     <= rhi_q;
            state_q       <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(MAX_INTERVALS))
    else $error("Stored count exceeds table depth.");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SCAN |-> ptr_q <= n_q)
    else $error("Scan pointer ran past the stored count.");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == FINISH))
    else $error("Result raised outside the finishing step.");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == StFull |-> out_count_q == CountW'(MAX_INTERVALS))
    else $error("Full status reported with free entries.");
`endif

endmodule
